>>> rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants for the calendar clock tick core
// Time-of-day and date record, beat kinds, rollover limits and the month
// codes that set month lengths.
// ----------------------------------------------------------------------------
package cct_pkg;

    // Calendar record; declared high field first so that second sits at bit 0
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [2:0]  weekday;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    localparam int CAL_W  = $bits(cal_t);
    localparam int DATA_W = ((CAL_W + 7) / 8) * 8;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // Rollover limits, compared against the incremented value
    localparam logic [6:0]  SEC_LIMIT   = 7'd60;
    localparam logic [6:0]  MIN_LIMIT   = 7'd60;
    localparam logic [5:0]  HOUR_LIMIT  = 6'd24;
    localparam logic [3:0]  WDAY_LIMIT  = 4'd8;
    localparam logic [4:0]  MONTH_LIMIT = 5'd13;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;

    localparam logic [2:0]  WDAY_FIRST  = 3'd1;
    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [4:0]  DAY_FIRST   = 5'd1;

    // Month codes with a length other than 31 days
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    localparam logic [4:0] LEN_LONG      = 5'd31;
    localparam logic [4:0] LEN_SHORT     = 5'd30;
    localparam logic [4:0] LEN_FEB_LEAP  = 5'd29;
    localparam logic [4:0] LEN_FEB_PLAIN = 5'd28;

    // year / 25 as (year * 5243) >> 17, exact for any 14-bit year
    localparam logic [12:0] DIV25_RECIP = 13'd5243;
    localparam int          DIV25_SHIFT = 17;
    localparam logic [4:0]  DIV25_BASE  = 5'd25;

    localparam cal_t CAL_RESET = '{
        year:    14'd2000,
        month:   4'd1,
        weekday: 3'd1,
        day:     5'd1,
        hour:    5'd0,
        minute:  6'd0,
        second:  6'd0
    };

endpackage

>>> rtl/calendar_clock_tick_core.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick_core: real-time clock and calendar
// Each input beat is a one-second tick or a load of the full time and date;
// each yields one output beat with the time and date after it.
//
//   Channel   Dir   Payload
//   s_*       in    tuser: op; tdata: load_second..load_year
//   m_*       out   tdata: second..year
//
// One beat per cycle sustained while the output is not stalled; each beat passes
// through the input register and the calendar register that also drives m_tdata.
// Reset sets 00:00:00, day 1, weekday 1, January 2000, with both stages empty.
// A stalled output holds its beat; one more input beat is taken meanwhile
// and then s_tready drops until the output moves.
// ----------------------------------------------------------------------------
module calendar_clock_tick_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [5:0] load_second, [11:6] load_minute, [16:12] load_hour, [21:17] load_day,
    // [24:22] load_weekday, [28:25] load_month, [42:29] load_year, rest zero
    input  logic [cct_pkg::DATA_W-1:0] s_tdata,
    // [0] op
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day,
    // [24:22] weekday, [28:25] month, [42:29] year, rest zero
    output logic [cct_pkg::DATA_W-1:0] m_tdata
);
    import cct_pkg::*;

    logic in_valid_reg;
    logic in_valid_next;
    op_t  in_op_reg;
    cal_t in_cal_reg;
    logic out_valid_reg;
    logic out_valid_next;
    cal_t cal_reg;
    cal_t cal_next;
    logic adv;

    // move the held beat into the calendar register when the output is free
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    cct_advance u_advance (
        .op  (in_op_reg),
        .cur (cal_reg),
        .ld  (in_cal_reg),
        .nxt (cal_next)
    );

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cal_reg       <= CAL_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                cal_reg <= cal_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= op_t'(s_tuser[0]);
            in_cal_reg <= cal_t'(s_tdata[CAL_W-1:0]);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_W - CAL_W){1'b0}}, cal_reg};

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced beat not presented");

    a_load_copies: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (in_op_reg == OP_LOAD)) |=> (cal_reg == $past(in_cal_reg)))
        else $error("load not taken as given");

    a_tick_second: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (in_op_reg == OP_TICK)) |=>
            ((cal_reg.second == 6'd0) || (cal_reg.second == $past(cal_reg.second) + 6'd1)))
        else $error("tick did not step seconds");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cal_reg))
        else $error("calendar changed without a beat");

endmodule

>>> rtl/cct_month_len.sv
// ----------------------------------------------------------------------------
// cct_month_len: length of the current month
// Gregorian leap test on the year and the day count for the month code.
// ----------------------------------------------------------------------------
module cct_month_len (
    input  logic [3:0]  month,
    input  logic [13:0] year,
    output logic [4:0]  length
);
    import cct_pkg::*;

    logic [26:0] prod;
    logic [9:0]  quot;
    logic [13:0] quot_x25;
    logic [4:0]  rem25;
    logic        leap;

    // divisible by 100 = divisible by 4 and 25; by 400 = by 16 and 25
    always_comb
    begin
        prod     = year * DIV25_RECIP;
        quot     = prod[DIV25_SHIFT +: 10];
        quot_x25 = 14'(quot * DIV25_BASE);
        rem25    = 5'(year - quot_x25);
        leap     = (year[1:0] == 2'b00) && ((rem25 != 5'd0) || (year[3:0] == 4'b0000));
    end

    always_comb
    begin
        unique case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: length = LEN_SHORT;
            MONTH_FEB: length = leap ? LEN_FEB_LEAP : LEN_FEB_PLAIN;
            default:   length = LEN_LONG;
        endcase
    end

endmodule

>>> rtl/cct_advance.sv
// ----------------------------------------------------------------------------
// cct_advance: next calendar state for one beat
// A load takes the given fields; a tick carries seconds up through the year.
// ----------------------------------------------------------------------------
module cct_advance (
    input  cct_pkg::op_t  op,
    input  cct_pkg::cal_t cur,
    input  cct_pkg::cal_t ld,
    output cct_pkg::cal_t nxt
);
    import cct_pkg::*;

    logic [4:0] month_days;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [3:0] wday_inc;
    logic [5:0] day_inc;
    logic [4:0] mon_inc;
    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       month_end;
    logic       mon_wrap;

    cct_month_len u_month_len (
        .month  (cur.month),
        .year   (cur.year),
        .length (month_days)
    );

    always_comb
    begin
        sec_inc   = {1'b0, cur.second} + 7'd1;
        min_inc   = {1'b0, cur.minute} + 7'd1;
        hour_inc  = {1'b0, cur.hour} + 6'd1;
        wday_inc  = {1'b0, cur.weekday} + 4'd1;
        day_inc   = {1'b0, cur.day} + 6'd1;
        mon_inc   = {1'b0, cur.month} + 5'd1;
        sec_wrap  = sec_inc >= SEC_LIMIT;
        min_wrap  = min_inc >= MIN_LIMIT;
        hour_wrap = hour_inc >= HOUR_LIMIT;
        month_end = day_inc > {1'b0, month_days};
        mon_wrap  = mon_inc >= MONTH_LIMIT;

        nxt = cur;
        if (op == OP_LOAD)
        begin
            nxt = ld;
        end
        else
        begin
            nxt.second = sec_wrap ? 6'd0 : sec_inc[5:0];
            if (sec_wrap)
            begin
                nxt.minute = min_wrap ? 6'd0 : min_inc[5:0];
            end
            if (sec_wrap && min_wrap)
            begin
                nxt.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
            end
            // day carry: weekday, then month and year when the month runs out
            if (sec_wrap && min_wrap && hour_wrap)
            begin
                nxt.weekday = ((wday_inc >= WDAY_LIMIT) || (cur.weekday == 3'd0))
                              ? WDAY_FIRST : wday_inc[2:0];
                nxt.day     = month_end ? DAY_FIRST : day_inc[4:0];
                if (month_end)
                begin
                    nxt.month = mon_wrap ? MONTH_FIRST : mon_inc[3:0];
                    if (mon_wrap)
                    begin
                        nxt.year = (cur.year >= YEAR_MAX) ? 14'd0 : cur.year + 14'd1;
                    end
                end
            end
        end
    end

endmodule
